/* rtl/cdf_pkg.sv */
`default_nettype none
package cdf_pkg;

	localparam int MAX_DISTINCT_DEF = 256;
	localparam int MAX_WORDS_DEF    = 16;

	localparam int WORD_W   = 32;
	localparam int CFG_W    = 5;
	localparam int IDX_W    = 8;
	localparam int M_DATA_W = 16;

	localparam logic [CFG_W-1:0] CERT_WORDS_RST = CFG_W'(16);

	// Result fields, lowest bit first: keep, entry_index, overflow.
	typedef struct packed {
		logic [M_DATA_W-IDX_W-3:0] pad;
		logic                      overflow;
		logic [IDX_W-1:0]          entry_index;
		logic                      keep;
	} result_t;

endpackage
`default_nettype wire

/* rtl/cdf_ram.sv */
`default_nettype none
module cdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/certificate_dedup_filter_unit.sv */
// Each input beat (one certificate word) is accepted in the receive state; no result follows a
// non-final word. After the final word, the store is scanned one word per cycle, limited by
// the single read port of the certificate store; the pending read is dropped after each
// mismatching entry. A new entry shorter than MAX_WORDS then has its tail zero-filled, and
// the result is loaded into the output register once that register is free.
// Reset empties the table at once (fill count zero), sets the length to 16 words.
`default_nettype none
module certificate_dedup_filter_unit
	import cdf_pkg::*;
#(
	parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
	parameter int MAX_WORDS    = MAX_WORDS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [WORD_W-1:0]   s_tdata,   // [31:0] cert_word
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata,   // [0] keep, [8:1] entry_index, [9] overflow
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	localparam int DEPTH = MAX_DISTINCT * MAX_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = $clog2(DEPTH + 1);
	localparam int EW    = $clog2(MAX_DISTINCT + 1);
	localparam int LW    = $clog2(MAX_WORDS + 1);
	localparam int CAW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	localparam logic [1:0] ST_RECV = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	localparam logic [EW-1:0] FULL_CNT = EW'(MAX_DISTINCT);
	localparam logic [LW-1:0] MW_L     = LW'(MAX_WORDS);
	localparam logic [BW-1:0] MW_B     = BW'(MAX_WORDS);

	logic [1:0]       state_q;
	logic [CFG_W-1:0] cert_words_q;
	logic [LW-1:0]    wp_q;
	logic [EW-1:0]    count_q;
	logic [BW-1:0]    fill_base_q;

	logic [EW-1:0]    ie_q;
	logic [LW-1:0]    ik_q;
	logic [BW-1:0]    ibase_q;

	logic             v_s1;
	logic [EW-1:0]    e_s1;
	logic [BW-1:0]    base_s1;
	logic             last_s1;

	result_t          res_q;
	logic             m_tvalid_q;
	result_t          m_tdata_q;

	logic [LW-1:0]    len;
	logic             s_acc;
	logic             word_last;
	logic             table_full;
	logic             out_free;

	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [WORD_W-1:0] st_wdata;
	logic [AW-1:0]    st_raddr;
	logic [WORD_W-1:0] st_rdata;
	logic [WORD_W-1:0] cur_rdata;
	logic             words_eq;

	always_comb begin
		if (cert_words_q == '0) begin
			len = LW'(1);
		end else if (32'(cert_words_q) > 32'(MAX_WORDS)) begin
			len = MW_L;
		end else begin
			len = LW'(cert_words_q);
		end
	end

	assign s_tready   = (state_q == ST_RECV);
	assign cfg_ready  = 1'b1;
	assign s_acc      = s_tvalid && s_tready;
	assign word_last  = (LW'(wp_q + LW'(1)) >= len) || (wp_q == MW_L);
	assign table_full = (count_q >= FULL_CNT);
	assign out_free   = !m_tvalid_q || m_tready;
	assign words_eq   = (st_rdata == cur_rdata);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Incoming words go straight into the next free row as well, so a new
	// certificate only needs its unused tail cleared.
	always_comb begin
		st_we    = 1'b0;
		st_waddr = AW'(fill_base_q + BW'(wp_q));
		st_wdata = s_tdata;
		if (state_q == ST_PAD) begin
			st_we    = 1'b1;
			st_waddr = AW'(fill_base_q + BW'(ik_q));
			st_wdata = '0;
		end else if (s_acc && !table_full) begin
			st_we = 1'b1;
		end
	end

	assign st_raddr = AW'(ibase_q + BW'(ik_q));

	cdf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	cdf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WORDS)
	) u_cur (
		.clk  (clk),
		.we   (s_acc),
		.waddr(wp_q[CAW-1:0]),
		.wdata(s_tdata),
		.raddr(ik_q[CAW-1:0]),
		.rdata(cur_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RECV;
			cert_words_q <= CERT_WORDS_RST;
			wp_q         <= '0;
			count_q      <= '0;
			fill_base_q  <= '0;
			ie_q         <= '0;
			ik_q         <= '0;
			ibase_q      <= '0;
			v_s1         <= 1'b0;
			res_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// A length write discards any partial certificate.
			if (cfg_valid && cfg_ready) begin
				cert_words_q <= cfg_data;
				wp_q         <= '0;
			end else if (s_acc) begin
				wp_q <= word_last ? '0 : wp_q + LW'(1);
			end

			unique case (state_q)
				ST_RECV: begin
					if (s_acc && word_last) begin
						ie_q    <= '0;
						ik_q    <= '0;
						ibase_q <= '0;
						v_s1    <= 1'b0;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (v_s1 && words_eq && last_s1) begin
						res_q.keep        <= 1'b0;
						res_q.entry_index <= IDX_W'(e_s1);
						res_q.overflow    <= 1'b0;
						v_s1              <= 1'b0;
						state_q           <= ST_HOLD;
					end else if (v_s1 && !words_eq) begin
						// Drop the read issued this cycle and restart at the first word of the next entry.
						ie_q    <= e_s1 + EW'(1);
						ik_q    <= '0;
						ibase_q <= base_s1 + MW_B;
						v_s1    <= 1'b0;
					end else if (ie_q < count_q) begin
						v_s1    <= 1'b1;
						e_s1    <= ie_q;
						base_s1 <= ibase_q;
						last_s1 <= (LW'(ik_q + LW'(1)) == len);
						if (LW'(ik_q + LW'(1)) == len) begin
							ik_q    <= '0;
							ie_q    <= ie_q + EW'(1);
							ibase_q <= ibase_q + MW_B;
						end else begin
							ik_q <= ik_q + LW'(1);
						end
					end else begin
						v_s1 <= 1'b0;
						if (table_full) begin
							res_q.keep        <= 1'b1;
							res_q.entry_index <= '0;
							res_q.overflow    <= 1'b1;
							state_q           <= ST_HOLD;
						end else begin
							res_q.keep        <= 1'b1;
							res_q.entry_index <= IDX_W'(count_q);
							res_q.overflow    <= 1'b0;
							if (len != MW_L) begin
								ik_q    <= len;
								state_q <= ST_PAD;
							end else begin
								count_q     <= count_q + EW'(1);
								fill_base_q <= fill_base_q + MW_B;
								state_q     <= ST_HOLD;
							end
						end
					end
				end
				ST_PAD: begin
					if (ik_q == LW'(MAX_WORDS - 1)) begin
						count_q     <= count_q + EW'(1);
						fill_base_q <= fill_base_q + MW_B;
						state_q     <= ST_HOLD;
					end else begin
						ik_q <= ik_q + LW'(1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_RECV;
					end
				end
				default: begin
					state_q <= ST_RECV;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			m_tdata_q <= res_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + EW'(1)))
		else $error("entry count moved by more than one");

	a_tag_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && v_s1) |-> (e_s1 < count_q))
		else $error("compare beat refers to an unfilled entry");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && res_q.overflow) |-> (count_q == FULL_CNT))
		else $error("overflow reported with free entries");

	a_base_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RECV) |-> (32'(fill_base_q) == 32'(count_q) * MAX_WORDS))
		else $error("fill base out of step with entry count");

endmodule
`default_nettype wire

/* tb/dedup_result_checker.sv */
`default_nettype none
module dedup_result_checker
	import cdf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [WORD_W-1:0]   s_tdata,   // [31:0] cert_word
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [M_DATA_W-1:0] m_tdata,   // [0] keep, [8:1] entry_index, [9] overflow
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	// Shadow copy of the certificate table and of the certificate being assembled.
	logic [WORD_W-1:0] table_words [MAX_DISTINCT_DEF][MAX_WORDS_DEF];
	logic [WORD_W-1:0] cert_buf [MAX_WORDS_DEF];
	int                stored_count;
	int                word_pos;
	logic [CFG_W-1:0]  length_reg;
	result_t           expected_verdicts [$];

	function automatic int span_of(input logic [CFG_W-1:0] r);
		if (r == '0)
			return 1;
		if (int'(r) > MAX_WORDS_DEF)
			return MAX_WORDS_DEF;
		return int'(r);
	endfunction

	task automatic absorb_cert_word(input logic [WORD_W-1:0] w);
		int      span;
		int      hit;
		result_t v;
		span = span_of(length_reg);
		if (word_pos >= span)
			word_pos = 0;
		cert_buf[word_pos] = w;
		word_pos++;
		if (word_pos < span)
			return;
		word_pos = 0;
		v = '0;
		hit = -1;
		for (int e = 0; e < stored_count && hit < 0; e++) begin
			hit = e;
			for (int k = 0; k < span; k++)
				if (table_words[e][k] != cert_buf[k])
					hit = -1;
		end
		if (hit >= 0) begin
			v.keep = 1'b0;
			v.entry_index = IDX_W'(hit);
		end else if (stored_count >= MAX_DISTINCT_DEF) begin
			v.keep = 1'b1;
			v.overflow = 1'b1;
		end else begin
			// Words past the current length are stored as zero.
			for (int k = 0; k < MAX_WORDS_DEF; k++)
				table_words[stored_count][k] = (k < span) ? cert_buf[k] : '0;
			v.keep = 1'b1;
			v.entry_index = IDX_W'(stored_count);
			stored_count++;
		end
		expected_verdicts.push_back(v);
	endtask

	task automatic check_verdict(input result_t got);
		result_t want;
		if (expected_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat: keep %0d entry_index %0d overflow %0d",
					got.keep, got.entry_index, got.overflow);
			return;
		end
		want = expected_verdicts.pop_front();
		if (got.keep !== want.keep || got.entry_index !== want.entry_index ||
				got.overflow !== want.overflow) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected keep %0d entry_index %0d overflow %0d, got keep %0d entry_index %0d overflow %0d",
					want.keep, want.entry_index, want.overflow,
					got.keep, got.entry_index, got.overflow);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count = 0;
			word_pos = 0;
			length_reg = CERT_WORDS_RST;
			expected_verdicts.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// A length write throws away any partly received certificate.
			if (cfg_valid && cfg_ready) begin
				length_reg = cfg_data;
				word_pos = 0;
			end
			if (s_tvalid && s_tready)
				absorb_cert_word(s_tdata);
			if (m_tvalid && m_tready)
				check_verdict(result_t'(m_tdata));
			outstanding <= expected_verdicts.size();
		end
	end

endmodule
`default_nettype wire

/* tb/certificate_dedup_filter_unit_test.sv */
`default_nettype none
module certificate_dedup_filter_unit_test;
	import cdf_pkg::*;

	// Longest scan of a full table of longest certificates, with some margin.
	localparam int DRAIN_CYCLES = MAX_DISTINCT_DEF * (MAX_WORDS_DEF + 1) + MAX_WORDS_DEF + 16;
	localparam int CYCLE_LIMIT  = 2_000_000;

	typedef logic [MAX_WORDS_DEF-1:0][WORD_W-1:0] cert_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [WORD_W-1:0]   s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	int    mismatches;
	int    outstanding;
	int    tx_idle_pct;
	int    rx_idle_pct;
	logic  hold_req;
	int    cycle_count;
	int    cur_len;
	cert_t cert_log [$];

	certificate_dedup_filter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dedup_result_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("certificate_dedup_filter_unit regression: fail");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin : result_sink
		logic hold_seen;
		int   hold_left;
		m_tready = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic push_word(input logic [WORD_W-1:0] w);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits until every result is in and any scan still running has finished.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_len = (v == '0) ? 1 : ((int'(v) > MAX_WORDS_DEF) ? MAX_WORDS_DEF : int'(v));
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			2: return WORD_W'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_cert(input cert_t c);
		for (int k = 0; k < cur_len; k++)
			push_word(c[k]);
	endtask

	task automatic send_fresh();
		cert_t c;
		c = '0;
		for (int k = 0; k < cur_len; k++)
			c[k] = pick_word();
		cert_log.push_back(c);
		send_cert(c);
	endtask

	// A repeat of an earlier certificate, now and then with one bit flipped.
	task automatic send_repeat();
		cert_t c;
		c = cert_log[$urandom_range(cert_log.size() - 1)];
		if ($urandom_range(3) == 0)
			c[$urandom_range(cur_len - 1)][$urandom_range(WORD_W - 1)] ^= 1'b1;
		send_cert(c);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] len_val, input int certs,
			input int repeat_pct, input int tx_pct, input int rx_pct, input bit long_hold);
		int tail;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_length(len_val);
		if (long_hold)
			hold_req <= ~hold_req;
		for (int n = 0; n < certs; n++) begin
			if (cert_log.size() > 0 && $urandom_range(99) < repeat_pct)
				send_repeat();
			else
				send_fresh();
		end
		// Sometimes leave a broken certificate behind for the next length write to discard.
		if (cur_len > 1 && $urandom_range(1) == 1) begin
			tail = $urandom_range(cur_len - 1, 1);
			for (int k = 0; k < tail; k++)
				push_word(pick_word());
		end
	endtask

	initial begin : stimulus
		cert_t c;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
		tx_idle_pct = 16;
		rx_idle_pct = 70;
		cur_len = MAX_WORDS_DEF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset length: a full-length certificate with all-ones ends.
		c = '0;
		c[0] = '1;
		c[MAX_WORDS_DEF-1] = '1;
		cert_log.push_back(c);
		send_cert(c);

		// Length zero acts as one word; all-ones matches the first entry on its first word.
		write_length('0);
		push_word('1);
		push_word('0);

		// Two zero words match the one-word zero entry through its zero fill.
		write_length(CFG_W'(2));
		push_word('0);
		push_word('0);

		// A partial certificate is dropped by a length write.
		write_length(CFG_W'(3));
		push_word(32'h0000_0005);
		write_length(CFG_W'(2));
		push_word(32'hA5A5_A5A5);
		push_word(32'h5A5A_5A5A);

		run_phase(CFG_W'(31), 6, 30, 16, 70, 1'b0);
		run_phase(CFG_W'(4), 15, 40, 16, 70, 1'b1);
		run_phase(CFG_W'(1), 330, 8, 70, 16, 1'b0);
		run_phase(CFG_W'(17), 6, 50, 70, 16, 1'b0);
		run_phase(CFG_W'(3), 15, 40, 0, 0, 1'b0);

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("certificate_dedup_filter_unit regression: pass");
		else
			$display("certificate_dedup_filter_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
